FILE: rtl/core/fibmm_pkg.sv
`timescale 1ns / 1ps
package fibmm_pkg;
    // Datapath operations driven by the controller
    typedef enum logic [2:0] {
        OP_NONE  = 3'd0,
        OP_LOAD  = 3'd1,
        OP_MUL   = 3'd2,
        OP_ACC   = 3'd3,
        OP_SQ    = 3'd4,
        OP_QMUL  = 3'd5
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [2:0] sel;   // product number 0..7 during a matrix square
    } cmd_t;

    typedef struct packed {
        logic mul_done;
        logic bit_set;     // current exponent bit
        logic last_bit;
    } stat_t;
endpackage

FILE: rtl/core/fibonacci_mod_matrix_power.sv
`timescale 1ns / 1ps
// A zero index or zero modulus answers zero without running the multiplier. One request at a time;
// the shared shift-add modular multiplier (one modulus bit per cycle) forms every product.
// Reset (rst_n, asynchronous, active low) returns the controller to idle.
module fibonacci_mod_matrix_power #(
    parameter int INDEX_BITS = 31,
    parameter int MOD_BITS   = 31
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [INDEX_BITS-1:0] index,
    input  logic [MOD_BITS-1:0]   modulus,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [30:0]           fib_residue
);
    import fibmm_pkg::*;
    cmd_t  cmd;
    stat_t stat;
    logic  use_zero;
    logic  [MOD_BITS-1:0] res;
    logic  [63:0] wide;

    fibmm_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .zero_case((index == '0) || (modulus == '0)),
        .out_valid(out_valid), .out_stall(out_stall), .use_zero(use_zero),
        .cmd(cmd), .stat(stat)
    );

    fibmm_datapath #(.INDEX_BITS(INDEX_BITS), .MOD_BITS(MOD_BITS)) u_dp (
        .clk(clk), .rst_n(rst_n), .index(index), .modulus(modulus),
        .cmd(cmd), .stat(stat), .res(res)
    );

    assign wide        = 64'(res);
    assign fib_residue = use_zero ? '0 : wide[30:0];
endmodule

FILE: rtl/core/fibmm_datapath.sv
`timescale 1ns / 1ps
module fibmm_datapath #(
    parameter int INDEX_BITS = 31,
    parameter int MOD_BITS   = 31
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [INDEX_BITS-1:0] index,
    input  logic [MOD_BITS-1:0]   modulus,
    input  fibmm_pkg::cmd_t       cmd,
    output fibmm_pkg::stat_t      stat,
    output logic [MOD_BITS-1:0]   res
);
    import fibmm_pkg::*;
    localparam int CW = $clog2(INDEX_BITS + 1);
    localparam int MW = $clog2(MOD_BITS + 1);

    logic [MOD_BITS-1:0]   m_reg, a_reg, b_reg, c_reg, d_reg;
    logic [MOD_BITS-1:0]   p_reg [4];  // new matrix entries being built
    logic [MOD_BITS-1:0]   r_reg, ma_reg, mb_reg;
    logic [INDEX_BITS-1:0] e_reg;
    logic [CW-1:0]         bit_reg;
    logic [MW-1:0]         mbit_reg;
    logic                  mbusy_reg;

    logic [MOD_BITS-1:0] opa, opb, r2, r3;

    function automatic logic [MOD_BITS-1:0] addm(input logic [MOD_BITS-1:0] x,
                                                 input logic [MOD_BITS-1:0] y,
                                                 input logic [MOD_BITS-1:0] m);
        logic [MOD_BITS:0] s;
        s = {1'b0, x} + {1'b0, y};
        if (s >= {1'b0, m})
            s = s - {1'b0, m};
        return s[MOD_BITS-1:0];
    endfunction

    // Product k of the square: entry k/2, term k%2
    always_comb
    begin
        unique case (cmd.sel)
            3'd0: begin opa = a_reg; opb = a_reg; end
            3'd1: begin opa = b_reg; opb = c_reg; end
            3'd2: begin opa = a_reg; opb = b_reg; end
            3'd3: begin opa = b_reg; opb = d_reg; end
            3'd4: begin opa = c_reg; opb = a_reg; end
            3'd5: begin opa = d_reg; opb = c_reg; end
            3'd6: begin opa = c_reg; opb = b_reg; end
            default: begin opa = d_reg; opb = d_reg; end
        endcase
    end

    always_comb
    begin
        r2 = addm(r_reg, r_reg, m_reg);
        r3 = mb_reg[mbit_reg[MW-1:0] - MW'(1)] ? addm(r2, ma_reg, m_reg) : r2;
    end

    assign stat.mul_done = !mbusy_reg;
    assign stat.bit_set  = e_reg[bit_reg[CW-1:0] - CW'(1)];
    assign stat.last_bit = (bit_reg == CW'(1));
    assign res = a_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mbusy_reg <= 1'b0;
            mbit_reg  <= '0;
            ma_reg    <= '0;
            mb_reg    <= '0;
            r_reg     <= '0;
        end
        else if (cmd.op == OP_MUL)
        begin
            ma_reg    <= opa;
            mb_reg    <= opb;
            r_reg     <= '0;
            mbit_reg  <= MW'(MOD_BITS);
            mbusy_reg <= 1'b1;
        end
        else if (mbusy_reg)
        begin
            r_reg    <= r3;
            mbit_reg <= mbit_reg - MW'(1);
            if (mbit_reg == MW'(1))
                mbusy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            OP_LOAD:
            begin
                m_reg   <= modulus;
                e_reg   <= index - INDEX_BITS'(1);
                bit_reg <= CW'(INDEX_BITS);
                a_reg   <= (modulus == MOD_BITS'(1)) ? '0 : MOD_BITS'(1);
                b_reg   <= '0;
                c_reg   <= '0;
                d_reg   <= (modulus == MOD_BITS'(1)) ? '0 : MOD_BITS'(1);
            end
            OP_ACC:
                if (!cmd.sel[0])
                    p_reg[cmd.sel[2:1]] <= r_reg;
                else
                    p_reg[cmd.sel[2:1]] <= addm(p_reg[cmd.sel[2:1]], r_reg, m_reg);
            OP_SQ:
            begin
                a_reg <= p_reg[0];
                b_reg <= p_reg[1];
                c_reg <= p_reg[2];
                d_reg <= p_reg[3];
            end
            OP_QMUL:
            begin
                if (stat.bit_set)
                begin
                    a_reg <= addm(a_reg, c_reg, m_reg);
                    b_reg <= addm(b_reg, d_reg, m_reg);
                    c_reg <= a_reg;
                    d_reg <= b_reg;
                end
                bit_reg <= bit_reg - CW'(1);
            end
            default: ;
        endcase
    end
endmodule

FILE: rtl/core/fibmm_ctrl.sv
`timescale 1ns / 1ps
module fibmm_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic             zero_case,
    output logic             out_valid,
    input  logic             out_stall,
    output logic             use_zero,
    output fibmm_pkg::cmd_t  cmd,
    input  fibmm_pkg::stat_t stat
);
    import fibmm_pkg::*;
    localparam logic [2:0] S_IDLE = 3'd0, S_MUL = 3'd1, S_WAIT = 3'd2,
                           S_ACC = 3'd3, S_SQ = 3'd4, S_Q = 3'd5, S_OUT = 3'd6;

    logic [2:0] state_reg, state_next;
    logic [2:0] k_reg, k_next;
    logic       z_reg, z_next;

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = (state_reg == S_OUT);
    assign use_zero  = z_reg;

    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        z_next     = z_reg;
        cmd.op     = OP_NONE;
        cmd.sel    = k_reg;
        unique case (state_reg)
            S_IDLE:
                if (in_valid)
                begin
                    cmd.op     = OP_LOAD;
                    z_next     = zero_case;
                    k_next     = '0;
                    state_next = zero_case ? S_OUT : S_MUL;
                end
            S_MUL:
            begin
                cmd.op     = OP_MUL;
                state_next = S_WAIT;
            end
            S_WAIT:
                if (stat.mul_done)
                    state_next = S_ACC;
            S_ACC:
            begin
                cmd.op     = OP_ACC;
                k_next     = k_reg + 3'd1;
                state_next = (k_reg == 3'd7) ? S_SQ : S_MUL;
            end
            S_SQ:
            begin
                cmd.op     = OP_SQ;
                state_next = S_Q;
            end
            S_Q:
            begin
                cmd.op     = OP_QMUL;
                state_next = stat.last_bit ? S_OUT : S_MUL;
            end
            S_OUT:
                if (!out_stall)
                    state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            k_reg     <= '0;
            z_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
            z_reg     <= z_next;
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid) else $error("result dropped");
    a_no_take: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> in_stall) else $error("request taken while busy");
    a_acc_after: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_ACC |-> stat.mul_done) else $error("product not ready");
endmodule

FILE: bench/tb_fibonacci_mod_matrix_power.sv
`timescale 1ns / 1ps
class fib_scoreboard;
    logic [30:0] residue_q[$];
    int errors;

    function new();
        errors = 0;
    endfunction

    // F(n) mod m, square-and-multiply over the bits of n-1, most significant first
    static function logic [30:0] fib_mod(logic [30:0] n, logic [30:0] m);
        logic [63:0] a, b, c, d, na, nb, nc, nd, e, mm;
        int i;
        if (m == 0 || n == 0)
            return 31'd0;
        mm = m;
        e = n - 1;
        a = 1 % mm;
        b = 0;
        c = 0;
        d = 1 % mm;
        for (i = 30; i >= 0; i--)
        begin
            na = (a * a + b * c) % mm;
            nb = (a * b + b * d) % mm;
            nc = (c * a + d * c) % mm;
            nd = (c * b + d * d) % mm;
            a = na;
            b = nb;
            c = nc;
            d = nd;
            if (e[i])
            begin
                na = (a + c) % mm;
                nb = (b + d) % mm;
                c = a;
                d = b;
                a = na;
                b = nb;
            end
        end
        return a[30:0];
    endfunction

    function void note_request(logic [30:0] n, logic [30:0] m);
        residue_q.push_back(fib_mod(n, m));
    endfunction

    task report(string msg);
        $display("ERROR: %s", msg);
        errors++;
    endtask

    task check_residue(logic [30:0] got);
        logic [30:0] want;
        if (residue_q.size() == 0)
        begin
            report($sformatf("unexpected residue %0d", got));
            return;
        end
        want = residue_q.pop_front();
        if (got !== want)
            report($sformatf("fib_residue got %0d want %0d", got, want));
    endtask
endclass

module tb_fibonacci_mod_matrix_power;

    localparam int WATCHDOG_LIMIT = 40000;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [30:0] index;
    logic [30:0] modulus;
    logic        out_valid;
    logic        out_stall;
    logic [30:0] fib_residue;

    fib_scoreboard board;
    int send_idle_pct;
    int stall_pct;
    int requests_sent;
    int residues_seen;
    int quiet_cycles;
    bit timed_out;

    fibonacci_mod_matrix_power DUT (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .index(index),
        .modulus(modulus),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .fib_residue(fib_residue)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Residue side: random stall, check every accepted result
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                board.check_residue(fib_residue);
                residues_seen++;
            end
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    always @(posedge clk)
    begin
        if (quiet_cycles >= WATCHDOG_LIMIT && !timed_out)
        begin
            timed_out = 1'b1;
            $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
            $display("fibonacci_mod_matrix_power verification failed");
            $finish;
        end
    end

    // Valid stays high after acceptance only until the next call in the same step
    task automatic send_request(logic [30:0] n, logic [30:0] m);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        index <= n;
        modulus <= m;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        board.note_request(n, m);
        requests_sent++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (board.residue_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic send_random(int count);
        logic [30:0] n, m;
        int k;
        for (k = 0; k < count; k++)
        begin
            case ($urandom_range(3))
                0: n = $urandom_range(40);
                1: n = $urandom;
                default: n = $urandom_range(100000);
            endcase
            case ($urandom_range(4))
                0: m = $urandom_range(1, 10);
                1: m = $urandom_range(1, 1000);
                2: m = 31'h7fffffff - $urandom_range(5);
                default: m = $urandom;
            endcase
            if ($urandom_range(49) == 0)
                m = 0;
            send_request(n, m);
        end
    endtask

    initial
    begin
        board = new();
        rst_n = 1'b0;
        in_valid = 1'b0;
        index = '0;
        modulus = '0;
        out_stall = 1'b0;
        send_idle_pct = 0;
        stall_pct = 0;
        requests_sent = 0;
        residues_seen = 0;
        quiet_cycles = 0;
        timed_out = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: zero index, n = 1, modulus one and zero, field extremes
        send_request(31'd0, 31'd7);
        send_request(31'd1, 31'd1);
        send_request(31'd1, 31'd100);
        send_request(31'd2, 31'd100);
        send_request(31'd10, 31'd1000);
        send_request(31'd5, 31'd0);
        send_request(31'd0, 31'd0);
        send_request(31'h7fffffff, 31'h7fffffff);
        send_request(31'h7fffffff, 31'd1);
        send_request(31'd46, 31'h7fffffff);
        send_request(31'd47, 31'h7fffffff);
        send_request(31'h55555555, 31'h2aaaaaaa);
        send_request(31'h2aaaaaaa, 31'h55555555);
        send_request(31'd90, 31'd2);
        send_request(31'h40000000, 31'h40000000);

        send_random(30);
        // Hold off until every outstanding residue is back
        drain();
        send_idle_pct = 80;
        send_random(30);
        send_idle_pct = 0;
        stall_pct = 80;
        send_random(30);
        send_idle_pct = 26;
        stall_pct = 26;
        send_random(30);
        stall_pct = 0;
        send_idle_pct = 0;

        drain();
        repeat (50) @(posedge clk);
        $display("covered %0d requests and %0d residues, across idle and stall phases",
                 requests_sent, residues_seen);
        $display("including zero index, moduli zero and one, and full-width fields");
        if (board.errors == 0 && board.residue_q.size() == 0)
            $display("fibonacci_mod_matrix_power verification clean");
        else
            $display("fibonacci_mod_matrix_power verification failed");
        $finish;
    end
endmodule
